### sv/tccp_pkg.sv
`default_nettype none
package tccp_pkg;
    localparam int CELL_SLOTS = 16;
    localparam int SLOT_BITS = 4;
    localparam int CAP_BITS = 48;
    localparam int CNT_BITS = 5;
    localparam int FRAC_BITS = 24;
    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
    localparam int ENTRY_BITS = 8 + 2 * CAP_BITS;

    localparam logic [1:0] ST_CHOSEN  = 2'd0;
    localparam logic [1:0] ST_DEFAULT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_WRITTEN = 2'd3;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_SEED  = 1'b1;

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction
endpackage
`default_nettype wire

### sv/tccp_ram.sv
`default_nettype none
module tccp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/tccp_divmod.sv
`default_nettype none
module tccp_divmod (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [31:0] dividend,
    input  wire  [6:0]  divisor,
    output logic        busy,
    output logic [6:0]  remainder
);
    logic [31:0] quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [7:0]  trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg, quo_reg[31]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = 7'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[6:0];
            end
            cnt_next = 6'(cnt_reg - 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign remainder = rem_reg;
endmodule
`default_nettype wire

### sv/tccp_mul.sv
`default_nettype none
module tccp_mul (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [47:0] a,
    input  wire  [47:0] b,
    output logic        busy,
    output logic [95:0] product
);
    logic [95:0] acc_reg, acc_next;
    logic [47:0] a_reg;
    logic [47:0] b_reg, b_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [63:0] part;

    assign part = a_reg * b_reg[15:0];

    always_comb
    begin
        acc_next = acc_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            acc_next = '0;
            b_next = b;
            cnt_next = 2'd3;
        end
        else if (cnt_reg != 2'd0)
        begin
            acc_next = {16'd0, acc_reg[95:16]} + {part, 32'd0};
            b_next = b_reg >> 16;
            cnt_next = 2'(cnt_reg - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg <= b_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign busy = (cnt_reg != 2'd0);
    assign product = acc_reg;
endmodule
`default_nettype wire

### sv/two_choice_cell_placement_core.sv
// A select with two cells runs two fraction divisions of up to 24 steps and a
// 32-step modulo; with more cells it draws two random choices and compares
// them, then may go on to extra random probes and a scan of the table.
// The core takes one item at a time and accepts no new item until idle.
// Reset: rst_n clears control, cell_count to 0 and the generator to 1; the
// cell table is undefined until written.
`default_nettype none
module two_choice_cell_placement_core (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // cmd[0], slot[4:1], cell_ident[12:5], limit_value[60:13], used_value[108:61]
    input  wire  [111:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status[1:0], chosen_slot[5:2], chosen_ident[13:6]
    output logic [15:0]  m_tdata,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire          cfg_index,
    input  wire  [31:0]  cfg_data
);
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RD     = 14'b00000000000010,
        S_FRAC   = 14'b00000000000100,
        S_DRAW   = 14'b00000000001000,
        S_MOD    = 14'b00000000010000,
        S_I1     = 14'b00000000100000,
        S_I2     = 14'b00000001000000,
        S_LD1    = 14'b00000010000000,
        S_LD2    = 14'b00000100000000,
        S_MUL    = 14'b00001000000000,
        S_CMP    = 14'b00010000000000,
        S_PROBE  = 14'b00100000000000,
        S_OUT    = 14'b01000000000000,
        S_SCAN   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic                       cmd_in;
    logic [3:0]                 slot_in;
    logic [7:0]                 ident_in;
    logic [47:0]                lim_in, use_in;

    assign cmd_in   = s_tdata[0];
    assign slot_in  = s_tdata[4:1];
    assign ident_in = s_tdata[12:5];
    assign lim_in   = s_tdata[60:13];
    assign use_in   = s_tdata[108:61];

    logic [4:0]  count_reg;
    logic [31:0] lfsr_reg, lfsr_next;
    logic        ovalid_reg;
    logic [15:0] odata_reg, odata_next;
    logic        ovalid_next;

    logic                              ram_we;
    logic [tccp_pkg::SLOT_BITS-1:0]    ram_raddr;
    logic [tccp_pkg::ENTRY_BITS-1:0]   ram_rdata;
    logic [7:0]                        rd_ident;
    logic [47:0]                       rd_lim, rd_use;

    tccp_ram #(.WIDTH(tccp_pkg::ENTRY_BITS), .DEPTH(tccp_pkg::CELL_SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_in),
        .wdata ({use_in, lim_in, ident_in}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
    assign rd_ident = ram_rdata[7:0];
    assign rd_lim   = ram_rdata[55:8];
    assign rd_use   = ram_rdata[103:56];

    logic        dm_start, dm_busy;
    logic [6:0]  dm_div, dm_rem;
    tccp_divmod u_div (
        .clk (clk), .rst_n (rst_n), .start (dm_start), .dividend (lfsr_reg),
        .divisor (dm_div), .busy (dm_busy), .remainder (dm_rem)
    );

    logic        mu_start, mu_busy;
    logic [47:0] mu_a, mu_b;
    logic [95:0] mu_p;
    tccp_mul u_mul (
        .clk (clk), .rst_n (rst_n), .start (mu_start), .a (mu_a), .b (mu_b),
        .busy (mu_busy), .product (mu_p)
    );

    // working registers
    logic [4:0]  n_reg, n_next;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  step_reg, step_next;
    logic [3:0]  i1_reg, i1_next, i2_reg, i2_next, cur_reg, cur_next;
    logic [47:0] l1_reg, l1_next, u1_reg, u1_next, l2_reg, l2_next, u2_reg, u2_next;
    logic [7:0]  id1_reg, id1_next, id2_reg, id2_next;
    logic [48:0] rem_reg, rem_next;
    logic [24:0] q_reg, q_next, q0_reg, q0_next;
    logic [95:0] pa_reg, pa_next;
    logic [48:0] rem_sh;
    logic [31:0] p0, p1, dd;
    logic [7:0]  dint;

    always_comb
    begin
        p0 = 32'(q0_reg) * 32'd100;
        p1 = 32'(q_reg) * 32'd100;
        dd = (p0 < p1) ? (p1 - p0) : (p0 - p1);
        dint = dd[31:24];
        rem_sh = {rem_reg[47:0], 1'b0};
    end

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;

    always_comb
    begin
        state_next = state_reg;
        lfsr_next = lfsr_reg;
        ovalid_next = ovalid_reg;
        odata_next = odata_reg;
        n_next = n_reg; phase_next = phase_reg; step_next = step_reg;
        i1_next = i1_reg; i2_next = i2_reg; cur_next = cur_reg;
        l1_next = l1_reg; u1_next = u1_reg; l2_next = l2_reg; u2_next = u2_reg;
        id1_next = id1_reg; id2_next = id2_reg;
        rem_next = rem_reg; q_next = q_reg; q0_next = q0_reg; pa_next = pa_reg;
        ram_we = 1'b0;
        ram_raddr = cur_reg;
        dm_start = 1'b0;
        dm_div = (phase_reg == 2'd1) ? 7'(n_reg - 5'd1) :
                 (phase_reg == 2'd3) ? 7'd100 : 7'(n_reg);
        mu_start = 1'b0;
        mu_a = u1_reg;
        mu_b = l2_reg;
        if (m_tvalid && m_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (cmd_in == tccp_pkg::CMD_WRITE)
                    begin
                        ram_we = 1'b1;
                        odata_next = {8'd0, 4'd0, tccp_pkg::ST_WRITTEN};
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        n_next = (count_reg > 5'd16) ? 5'd16 : count_reg;
                        if (n_next == 5'd0)
                        begin
                            odata_next = {8'd0, 4'd0, tccp_pkg::ST_DEFAULT};
                            ovalid_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = 4'd0;
                            ram_raddr = 4'd0;
                            phase_next = 2'd0;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                // table data for cur_reg available now
                if (n_reg == 5'd1)
                begin
                    odata_next = {rd_ident, 4'd0, tccp_pkg::ST_CHOSEN};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (n_reg == 5'd2)
                begin
                    if (cur_reg == 4'd0)
                    begin
                        id1_next = rd_ident;
                    end
                    else
                    begin
                        id2_next = rd_ident;
                    end
                    l1_next = rd_lim;
                    rem_next = {1'b0, rd_lim - rd_use};
                    q_next = '0;
                    step_next = 6'd24;
                    if (rd_lim == 48'd0 || rd_use >= rd_lim)
                    begin
                        step_next = 6'd0;
                    end
                    else if (rd_use == 48'd0)
                    begin
                        q_next = 25'h100_0000;
                        step_next = 6'd0;
                    end
                    state_next = S_FRAC;
                end
                else
                begin
                    state_next = S_DRAW;
                end
            end
            S_FRAC:
            begin
                if (step_reg != 6'd0)
                begin
                    q_next = {q_reg[23:0], 1'b0};
                    if (rem_sh >= {1'b0, l1_reg})
                    begin
                        rem_next = rem_sh - {1'b0, l1_reg};
                        q_next[0] = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_sh;
                    end
                    step_next = 6'(step_reg - 6'd1);
                end
                else if (cur_reg == 4'd0)
                begin
                    q0_next = q_reg;
                    cur_next = 4'd1;
                    ram_raddr = 4'd1;
                    state_next = S_RD;
                end
                else
                begin
                    phase_next = 2'd3;
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                lfsr_next = tccp_pkg::lfsr_step(lfsr_reg);
                state_next = S_MOD;
                step_next = 6'd0;
            end
            S_MOD:
            begin
                if (step_reg == 6'd0)
                begin
                    dm_start = 1'b1;
                    step_next = 6'd1;
                end
                else if (!dm_busy)
                begin
                    step_next = 6'd0;
                    case (phase_reg)
                        2'd0:
                        begin
                            i1_next = dm_rem[3:0];
                            phase_next = 2'd1;
                            state_next = S_DRAW;
                        end
                        2'd1:
                        begin
                            i2_next = (dm_rem[3:0] >= i1_reg) ? 4'(dm_rem[3:0] + 4'd1)
                                                              : dm_rem[3:0];
                            cur_next = i1_reg;
                            ram_raddr = i1_reg;
                            state_next = S_LD1;
                        end
                        2'd2:
                        begin
                            cur_next = dm_rem[3:0];
                            ram_raddr = dm_rem[3:0];
                            state_next = S_PROBE;
                        end
                        default:
                        begin
                            if ({1'b0, dm_rem} > 8'd50 + dint && (q0_reg < q_reg))
                            begin
                                odata_next = {id1_reg, 4'd0, tccp_pkg::ST_CHOSEN};
                            end
                            else if ({1'b0, dm_rem} > 8'd50 + dint)
                            begin
                                odata_next = {id2_reg, 4'd1, tccp_pkg::ST_CHOSEN};
                            end
                            else if (q0_reg < q_reg)
                            begin
                                odata_next = {id2_reg, 4'd1, tccp_pkg::ST_CHOSEN};
                            end
                            else
                            begin
                                odata_next = {id1_reg, 4'd0, tccp_pkg::ST_CHOSEN};
                            end
                            ovalid_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LD1:
            begin
                l1_next = rd_lim; u1_next = rd_use; id1_next = rd_ident;
                cur_next = i2_reg;
                ram_raddr = i2_reg;
                state_next = S_LD2;
            end
            S_LD2:
            begin
                l2_next = rd_lim; u2_next = rd_use; id2_next = rd_ident;
                if (l1_reg == 48'd0)
                begin
                    odata_next = {rd_ident, i2_reg, tccp_pkg::ST_CHOSEN};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (rd_lim == 48'd0)
                begin
                    odata_next = {id1_reg, i1_reg, tccp_pkg::ST_CHOSEN};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mu_start = 1'b1;
                    mu_b = rd_lim;
                    step_next = 6'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (!mu_busy)
                begin
                    pa_next = mu_p;
                    mu_start = 1'b1;
                    mu_a = u2_reg;
                    mu_b = l1_reg;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!mu_busy)
                begin
                    if (pa_reg < mu_p)
                    begin
                        odata_next = {id1_reg, i1_reg, tccp_pkg::ST_CHOSEN};
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (u2_reg < l2_reg)
                    begin
                        odata_next = {id2_reg, i2_reg, tccp_pkg::ST_CHOSEN};
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = 2'd2;
                        step_next = 6'd0;
                        n_next = n_reg;
                        i1_next = 4'd0;
                        l1_next = {43'd0, n_reg} << 1;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // probe budget counter in l1_reg
                if (l1_reg != 48'd0)
                begin
                    l1_next = l1_reg - 48'd1;
                    state_next = S_DRAW;
                end
                else
                begin
                    cur_next = 4'd0;
                    ram_raddr = 4'd0;
                    state_next = S_SCAN;
                end
            end
            S_PROBE:
            begin
                if (rd_use < rd_lim)
                begin
                    odata_next = {rd_ident, cur_reg, tccp_pkg::ST_CHOSEN};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (rd_use < rd_lim)
                begin
                    odata_next = {rd_ident, cur_reg, tccp_pkg::ST_CHOSEN};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (5'(cur_reg) + 5'd1 >= n_reg)
                begin
                    odata_next = {8'd0, 4'd0, tccp_pkg::ST_FULL};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = 4'(cur_reg + 4'd1);
                    ram_raddr = cur_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_valid && cfg_ready && cfg_index == tccp_pkg::REG_SEED)
        begin
            lfsr_next = (cfg_data == 32'd0) ? 32'd1 : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lfsr_reg <= 32'd1;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lfsr_reg <= lfsr_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready && cfg_index == tccp_pkg::REG_COUNT)
            begin
                count_reg <= cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        n_reg <= n_next; phase_reg <= phase_next; step_reg <= step_next;
        i1_reg <= i1_next; i2_reg <= i2_next; cur_reg <= cur_next;
        l1_reg <= l1_next; u1_reg <= u1_next; l2_reg <= l2_next; u2_reg <= u2_next;
        id1_reg <= id1_next; id2_reg <= id2_next;
        rem_reg <= rem_next; q_reg <= q_next; q0_reg <= q0_next; pa_reg <= pa_next;
    end

    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    ap_i2_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD1) |-> (i1_reg != i2_reg))
        else $error("two choices equal");
    ap_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 32'd0)
        else $error("generator stuck at zero");
endmodule
`default_nettype wire
